/* hdl/bld_pkg.sv */
// shared types and constants for the bounded list block
`default_nettype none

package bld_pkg;

    localparam int DEPTH    = 16;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 5;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int RIP_W    = $clog2(DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DELETE     = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_BACK,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_MATCH,
        CELL_RIPPLE,
        CELL_COMPACT
    } cell_op_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_RIPPLE,
        FSM_COMPACT
    } fsm_t;

    typedef struct packed {
        cell_op_t          op;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/bld_cell.sv */
// one list position: holds an entry and its match and ripple flags
`default_nettype none

module bld_cell
    import bld_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic              sel,
    input  wire logic              live,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    input  wire logic              left_seen,
    output logic [DATA_W-1:0]      data,
    output logic                   seen
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit_reg;
    logic              hit_next;
    logic              pass_reg;
    logic              pass_next;

    always_comb
    begin
        data_next = data_reg;
        hit_next  = hit_reg;
        pass_next = pass_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_PUSH_BACK:
            begin
                if (sel)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_SHIFT_UP:
            begin
                data_next = left_data;
            end
            CELL_SHIFT_DOWN:
            begin
                data_next = right_data;
            end
            CELL_MATCH:
            begin
                hit_next  = live && (data_reg == ctrl.value);
                pass_next = 1'b0;
            end
            CELL_RIPPLE:
            begin
                // a match further toward the front travels one cell per cycle
                pass_next = left_seen;
            end
            CELL_COMPACT:
            begin
                // at or behind the first match: close the gap
                if (pass_reg || hit_reg)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            pass_reg <= 1'b0;
        end
        else
        begin
            hit_reg  <= hit_next;
            pass_reg <= pass_next;
        end
    end

    assign data = data_reg;
    assign seen = pass_reg || hit_reg;

endmodule

`default_nettype wire

/* hdl/bounded_list_with_delete_by_value.sv */
// top level of the bounded ordered list with delete by value
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   in      | in_valid, in_stall, command,    | beat in
//           | value                           |
//   out     | out_valid, out_stall, status,   | beat out
//           | entry_count                     |
//
// push, pop and clear finish in the cycle of acceptance.
// find and delete runs in steps: a compare in every cell, the match flag
// rippling down the chain of cells, then one compact.
// the result sits in an output register; a new item is taken while it is
// being taken by the sink. reset empties the list; entries are not cleared.
`default_nettype none

module bounded_list_with_delete_by_value
    import bld_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic signed [31:0]  value,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [ENTRY_W-1:0]       entry_count
);

    fsm_t                state_reg;
    fsm_t                state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [RIP_W-1:0]    rip_reg;
    logic [RIP_W-1:0]    rip_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    status_t             res_status_reg;
    status_t             res_status_next;
    logic [ENTRY_W-1:0]  res_count_reg;
    logic [ENTRY_W-1:0]  res_count_next;

    cell_ctrl_t          ctrl;
    logic                accept;
    logic                load_res;
    logic                full;
    logic                empty;
    logic [DATA_W-1:0]   cell_data [DEPTH];
    logic [DEPTH-1:0]    cell_seen;
    logic [DEPTH-1:0]    cell_sel;
    logic [DEPTH-1:0]    cell_live;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign accept = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept && (command == CMD_DELETE) && !empty)
                begin
                    state_next = FSM_RIPPLE;
                end
            end
            FSM_RIPPLE:
            begin
                if (rip_reg == RIP_W'(DEPTH - 2))
                begin
                    state_next = FSM_COMPACT;
                end
            end
            FSM_COMPACT:
            begin
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_stall        = (state_reg != FSM_IDLE) || (res_valid_reg && out_stall);
        ctrl.op         = CELL_HOLD;
        ctrl.value      = DATA_W'(value);
        count_next      = count_reg;
        rip_next        = rip_reg;
        load_res        = 1'b0;
        res_status_next = res_status_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    load_res        = 1'b1;
                    res_status_next = STATUS_OK;
                    unique case (command)
                        CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.op    = CELL_SHIFT_UP;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.op    = CELL_PUSH_BACK;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                ctrl.op    = CELL_SHIFT_DOWN;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                load_res = 1'b0;
                                ctrl.op  = CELL_MATCH;
                                rip_next = '0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            FSM_RIPPLE:
            begin
                ctrl.op  = CELL_RIPPLE;
                rip_next = rip_reg + 1'b1;
            end
            FSM_COMPACT:
            begin
                ctrl.op  = CELL_COMPACT;
                load_res = 1'b1;
                if (cell_seen[DEPTH-1])
                begin
                    res_status_next = STATUS_OK;
                    count_next      = count_reg - 1'b1;
                end
                else
                begin
                    res_status_next = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        res_valid_next = load_res || (res_valid_reg && out_stall);
        res_count_next = load_res ? ENTRY_W'(count_next) : res_count_reg;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign cell_sel[i]  = (count_reg == CNT_W'(i));
        assign cell_live[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            // the head takes the pushed value and sees nothing in front
            bld_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sel        (cell_sel[i]),
                .live       (cell_live[i]),
                .left_data  (ctrl.value),
                .right_data (cell_data[i+1]),
                .left_seen  (1'b0),
                .data       (cell_data[i]),
                .seen       (cell_seen[i])
            );
        end
        else if (i == DEPTH - 1)
        begin : g_tail
            bld_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sel        (cell_sel[i]),
                .live       (cell_live[i]),
                .left_data  (cell_data[i-1]),
                .right_data (cell_data[i]),
                .left_seen  (cell_seen[i-1]),
                .data       (cell_data[i]),
                .seen       (cell_seen[i])
            );
        end
        else
        begin : g_mid
            bld_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sel        (cell_sel[i]),
                .live       (cell_live[i]),
                .left_data  (cell_data[i-1]),
                .right_data (cell_data[i+1]),
                .left_seen  (cell_seen[i-1]),
                .data       (cell_data[i]),
                .seen       (cell_seen[i])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            rip_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rip_reg       <= rip_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
    end

    assign out_valid   = res_valid_reg;
    assign status      = res_status_reg;
    assign entry_count = res_count_reg;

endmodule

`default_nettype wire
